### rtl/incubator_climate_controller_defines.svh
// ----------------------------------------------------------------------------
// Incubator climate controller assertion macros
// Shared concurrent assertion forms used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef INCUBATOR_CLIMATE_CONTROLLER_DEFINES_SVH
`define INCUBATOR_CLIMATE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define ICC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icc assertion failed");

// next-cycle implication
`define ICC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icc assertion failed");

`endif

### rtl/icc_pkg.sv
// ----------------------------------------------------------------------------
// icc_pkg
// Types, register indexes and reset values of the incubator climate controller.
// ----------------------------------------------------------------------------
package icc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SP_MIN      = 3'd0,
      CSR_SP_MAX      = 3'd1,
      CSR_OX_OPEN     = 3'd2,
      CSR_OX_CLOSE    = 3'd3,
      CSR_MARGIN      = 3'd4,
      CSR_HUM_LOW     = 3'd5,
      CSR_HUM_OK_LOW  = 3'd6,
      CSR_HUM_OK_HIGH = 3'd7
   } csr_index_type;

   localparam logic [5:0] SP_MIN_RST      = 6'd20;
   localparam logic [5:0] SP_MAX_RST      = 6'd35;
   localparam logic [7:0] OX_OPEN_RST     = 8'd64;
   localparam logic [7:0] OX_CLOSE_RST    = 8'd75;
   localparam logic [3:0] MARGIN_RST      = 4'd3;
   localparam logic [7:0] HUM_LOW_RST     = 8'd45;
   localparam logic [7:0] HUM_OK_LOW_RST  = 8'd55;
   localparam logic [7:0] HUM_OK_HIGH_RST = 8'd60;
   localparam logic [5:0] SETPOINT_RST    = 6'd25;

   typedef struct packed {
      logic [5:0] sp_min;
      logic [5:0] sp_max;
      logic [7:0] ox_open;
      logic [7:0] ox_close;
      logic [3:0] margin;
      logic [7:0] hum_low;
      logic [7:0] hum_ok_low;
      logic [7:0] hum_ok_high;
   } cfg_type;

   typedef struct packed {
      logic       sensor_ok;
      logic [7:0] humidity_high;
      logic [7:0] humidity_low;
      logic [7:0] temperature_high;
      logic [7:0] temperature_low;
      logic [7:0] checksum_byte;
      logic [7:0] oxygen_level;
      logic       adjust_mode;
      logic       raise_pressed;
      logic       lower_pressed;
   } req_type;

   typedef struct packed {
      logic       valve_on;
      logic       heater_on;
      logic       humidifier_on;
      logic       cooler_on;
      logic [5:0] setpoint_now;
      logic [7:0] humidity_now;
      logic [7:0] temperature_now;
      logic       reading_bad;
   } rsp_type;

endpackage

### rtl/icc_if.sv
// ----------------------------------------------------------------------------
// icc_if
// Valid/ready channels carrying controller request and result items.
// ----------------------------------------------------------------------------
interface icc_req_if;
   logic       valid;
   logic       ready;
   logic       sensor_ok;
   logic [7:0] humidity_high;
   logic [7:0] humidity_low;
   logic [7:0] temperature_high;
   logic [7:0] temperature_low;
   logic [7:0] checksum_byte;
   logic [7:0] oxygen_level;
   logic       adjust_mode;
   logic       raise_pressed;
   logic       lower_pressed;

   modport source (
      output valid, sensor_ok, humidity_high, humidity_low, temperature_high,
             temperature_low, checksum_byte, oxygen_level, adjust_mode,
             raise_pressed, lower_pressed,
      input  ready
   );

   modport sink (
      input  valid, sensor_ok, humidity_high, humidity_low, temperature_high,
             temperature_low, checksum_byte, oxygen_level, adjust_mode,
             raise_pressed, lower_pressed,
      output ready
   );
endinterface

interface icc_rsp_if;
   logic       valid;
   logic       ready;
   logic       valve_on;
   logic       heater_on;
   logic       humidifier_on;
   logic       cooler_on;
   logic [5:0] setpoint_now;
   logic [7:0] humidity_now;
   logic [7:0] temperature_now;
   logic       reading_bad;

   modport source (
      output valid, valve_on, heater_on, humidifier_on, cooler_on, setpoint_now,
             humidity_now, temperature_now, reading_bad,
      input  ready
   );

   modport sink (
      input  valid, valve_on, heater_on, humidifier_on, cooler_on, setpoint_now,
             humidity_now, temperature_now, reading_bad,
      output ready
   );
endinterface

### rtl/icc_csr.sv
// ----------------------------------------------------------------------------
// icc_csr
// Configuration register file: thresholds and setpoint limits.
// ----------------------------------------------------------------------------
module icc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [icc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [icc_pkg::CSR_DATA_W-1:0]     csr_data,
   output icc_pkg::cfg_type                   cfg
);

   icc_pkg::cfg_type cfg_ff;
   icc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (icc_pkg::csr_index_type'(csr_index))
            icc_pkg::CSR_SP_MIN:      cfg_in.sp_min      = csr_data[5:0];
            icc_pkg::CSR_SP_MAX:      cfg_in.sp_max      = csr_data[5:0];
            icc_pkg::CSR_OX_OPEN:     cfg_in.ox_open     = csr_data;
            icc_pkg::CSR_OX_CLOSE:    cfg_in.ox_close    = csr_data;
            icc_pkg::CSR_MARGIN:      cfg_in.margin      = csr_data[3:0];
            icc_pkg::CSR_HUM_LOW:     cfg_in.hum_low     = csr_data;
            icc_pkg::CSR_HUM_OK_LOW:  cfg_in.hum_ok_low  = csr_data;
            icc_pkg::CSR_HUM_OK_HIGH: cfg_in.hum_ok_high = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sp_min      <= icc_pkg::SP_MIN_RST;
         cfg_ff.sp_max      <= icc_pkg::SP_MAX_RST;
         cfg_ff.ox_open     <= icc_pkg::OX_OPEN_RST;
         cfg_ff.ox_close    <= icc_pkg::OX_CLOSE_RST;
         cfg_ff.margin      <= icc_pkg::MARGIN_RST;
         cfg_ff.hum_low     <= icc_pkg::HUM_LOW_RST;
         cfg_ff.hum_ok_low  <= icc_pkg::HUM_OK_LOW_RST;
         cfg_ff.hum_ok_high <= icc_pkg::HUM_OK_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/icc_core.sv
// ----------------------------------------------------------------------------
// icc_core
// Controller state and one-pass update: reading check, setpoint buttons and
// hysteresis rules for valve, heater, humidifier and cooler.
// ----------------------------------------------------------------------------
module icc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  icc_pkg::cfg_type  cfg,
   input  icc_pkg::req_type  req,
   output icc_pkg::rsp_type  rsp
);

   logic [7:0] hum_ff, hum_in;
   logic [7:0] temp_ff, temp_in;
   logic [5:0] sp_ff, sp_in;
   logic       valve_ff, valve_in;
   logic       heater_ff, heater_in;
   logic       by_temp_ff, by_temp_in;
   logic       humid_ff, humid_in;
   logic       cooler_ff, cooler_in;

   logic [7:0] sum8;
   logic       ck_ok;
   logic       bad;
   logic [5:0] sp_up;
   logic [8:0] t_plus_m;
   logic [6:0] sp_plus_m;
   logic       t_eq_sp;

   always_comb begin
      sum8  = req.humidity_high + req.humidity_low + req.temperature_high
            + req.temperature_low;
      ck_ok = (sum8 == req.checksum_byte);
      bad   = req.sensor_ok && !ck_ok;

      hum_in  = hum_ff;
      temp_in = temp_ff;
      if (req.sensor_ok && ck_ok) begin
         hum_in  = req.humidity_high;
         temp_in = req.temperature_high;
      end

      sp_up = sp_ff;
      if (req.adjust_mode && req.raise_pressed && (sp_ff < cfg.sp_max)) begin
         sp_up = sp_ff + 6'd1;
      end
      sp_in = sp_up;
      if (req.adjust_mode && req.lower_pressed && (sp_up > cfg.sp_min)) begin
         sp_in = sp_up - 6'd1;
      end

      valve_in = valve_ff;
      if (req.oxygen_level <= cfg.ox_open) begin
         valve_in = 1'b1;
      end else if (req.oxygen_level >= cfg.ox_close) begin
         valve_in = 1'b0;
      end

      t_plus_m  = {1'b0, temp_in} + {5'd0, cfg.margin};
      sp_plus_m = {1'b0, sp_in} + {3'd0, cfg.margin};
      t_eq_sp   = (temp_in == {2'd0, sp_in});

      heater_in  = heater_ff;
      by_temp_in = by_temp_ff;
      if (t_plus_m <= {3'd0, sp_in}) begin
         heater_in  = 1'b1;
         by_temp_in = 1'b1;
      end else if (t_eq_sp) begin
         heater_in  = 1'b0;
         by_temp_in = 1'b0;
      end

      humid_in = humid_ff;
      if (hum_in < cfg.hum_low) begin
         humid_in = 1'b1;
      end else if ((hum_in >= cfg.hum_ok_low) && (hum_in <= cfg.hum_ok_high)) begin
         humid_in = 1'b0;
         if (!by_temp_in) begin
            heater_in = 1'b0;
         end
      end else if (hum_in > cfg.hum_ok_high) begin
         heater_in = 1'b1;
      end

      cooler_in = cooler_ff;
      if ({1'b0, temp_in} >= {2'd0, sp_plus_m}) begin
         cooler_in = 1'b1;
      end else if (t_eq_sp) begin
         cooler_in = 1'b0;
      end

      rsp.valve_on        = valve_in;
      rsp.heater_on       = heater_in;
      rsp.humidifier_on   = humid_in;
      rsp.cooler_on       = cooler_in;
      rsp.setpoint_now    = sp_in;
      rsp.humidity_now    = hum_in;
      rsp.temperature_now = temp_in;
      rsp.reading_bad     = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_ff     <= 8'd0;
         temp_ff    <= 8'd0;
         sp_ff      <= icc_pkg::SETPOINT_RST;
         valve_ff   <= 1'b0;
         heater_ff  <= 1'b0;
         by_temp_ff <= 1'b0;
         humid_ff   <= 1'b0;
         cooler_ff  <= 1'b0;
      end else if (step) begin
         hum_ff     <= hum_in;
         temp_ff    <= temp_in;
         sp_ff      <= sp_in;
         valve_ff   <= valve_in;
         heater_ff  <= heater_in;
         by_temp_ff <= by_temp_in;
         humid_ff   <= humid_in;
         cooler_ff  <= cooler_in;
      end
   end

endmodule

### rtl/incubator_climate_controller.sv
// ----------------------------------------------------------------------------
// incubator_climate_controller
// Incubator climate control loop: one request item per control cycle, one
// result item with actuator drives, setpoint and last good readings.
// ----------------------------------------------------------------------------
// Each request item is one control cycle and yields exactly one result item.
// The block accepts one item per clock while results are taken; a result is
// formed from its item in the input register, then held in the result register
// until taken. A stalled result holds the input register and drops req ready.
// The controller state in icc_core is committed as an item moves from the
// input register to the result register. Thresholds are written through the
// csr_ port and take effect for items that reach the update after the write;
// write them only while the block is idle.
`include "incubator_climate_controller_defines.svh"

module incubator_climate_controller (
   input  logic                             clock,
   input  logic                             reset,
   icc_req_if.sink                          req_ch,
   icc_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [icc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [icc_pkg::CSR_DATA_W-1:0]   csr_data
);

   icc_pkg::cfg_type cfg;
   icc_pkg::req_type req_bus;
   icc_pkg::req_type in_data_ff, in_data_in;
   icc_pkg::rsp_type out_data_ff, out_data_in;
   icc_pkg::rsp_type core_rsp;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             req_take;
   logic             advance;

   assign req_bus.sensor_ok        = req_ch.sensor_ok;
   assign req_bus.humidity_high    = req_ch.humidity_high;
   assign req_bus.humidity_low     = req_ch.humidity_low;
   assign req_bus.temperature_high = req_ch.temperature_high;
   assign req_bus.temperature_low  = req_ch.temperature_low;
   assign req_bus.checksum_byte    = req_ch.checksum_byte;
   assign req_bus.oxygen_level     = req_ch.oxygen_level;
   assign req_bus.adjust_mode      = req_ch.adjust_mode;
   assign req_bus.raise_pressed    = req_ch.raise_pressed;
   assign req_bus.lower_pressed    = req_ch.lower_pressed;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   icc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   icc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cfg   (cfg),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_bus;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = core_rsp;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.valve_on        = out_data_ff.valve_on;
   assign rsp_ch.heater_on       = out_data_ff.heater_on;
   assign rsp_ch.humidifier_on   = out_data_ff.humidifier_on;
   assign rsp_ch.cooler_on       = out_data_ff.cooler_on;
   assign rsp_ch.setpoint_now    = out_data_ff.setpoint_now;
   assign rsp_ch.humidity_now    = out_data_ff.humidity_now;
   assign rsp_ch.temperature_now = out_data_ff.temperature_now;
   assign rsp_ch.reading_bad     = out_data_ff.reading_bad;

   `ICC_ASSERT_NEXT(a_take_fills_input, clock, reset, req_take, in_valid_ff)
   `ICC_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, out_valid_ff)
   `ICC_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_data_ff))
   `ICC_ASSERT_IMPL(a_advance_has_room, clock, reset, advance, !out_valid_ff || rsp_ch.ready)

endmodule
